FILE: rtl/ising_heat_bath_site_update_defines.svh
// ----------------------------------------------------------------------------
// ising heat bath site update: assertion macros
// shared check macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ISING_HEAT_BATH_SITE_UPDATE_DEFINES_SVH
`define ISING_HEAT_BATH_SITE_UPDATE_DEFINES_SVH

// same-cycle implication
`define IHB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IHB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ihb_pkg.sv
// ----------------------------------------------------------------------------
// ihb_pkg
// lattice size, field widths, register codes and shared types
// ----------------------------------------------------------------------------
package ihb_pkg;

    localparam int ROWS     = 64;
    localparam int COLS     = 64;
    localparam int ROW_AW   = $clog2(ROWS);
    localparam int COL_AW   = $clog2(COLS);
    localparam int ROW_IN_W = 6;
    localparam int COL_IN_W = 6;
    localparam int WRAP_W   = 19;

    localparam int PROB_W   = 32;
    localparam int NUM_PROB = 5;
    localparam int CNT_W    = 3;

    localparam logic [PROB_W-1:0] HALF_WORD  = 32'h8000_0000;
    localparam logic [PROB_W-1:0] PROB_RESET = 32'h8000_0000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_PROB_M4 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_PROB_M2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_PROB_Z0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_PROB_P2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_PROB_P4 = 3'd4;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    typedef logic [NUM_PROB-1:0][PROB_W-1:0] prob_tab_t;

    typedef struct packed {
        logic spin;
        logic flipped;
        logic wr;
    } calc_res_t;

    // input index modulo m by restoring reduction, one shifted compare per input bit
    function automatic logic [WRAP_W-1:0] wrap_index(input logic [ROW_IN_W-1:0] v,
                                                     input int unsigned m);
        logic [WRAP_W-1:0] x;
        logic [WRAP_W-1:0] step;
        x = WRAP_W'(v);
        for (int k = ROW_IN_W - 1; k >= 0; k--) begin
            step = WRAP_W'(m) << k;
            if (x >= step) begin
                x = x - step;
            end
        end
        return x;
    endfunction

endpackage

FILE: rtl/ihb_ram.sv
// ----------------------------------------------------------------------------
// ihb_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module ihb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // read during write returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

FILE: rtl/ihb_cfg_regs.sv
// ----------------------------------------------------------------------------
// ihb_cfg_regs
// flip threshold registers, written through the config channel
// ----------------------------------------------------------------------------
module ihb_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [ihb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ihb_pkg::PROB_W-1:0]       cfg_data,
    output ihb_pkg::prob_tab_t               probs
);

    ihb_pkg::prob_tab_t prob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ihb_pkg::NUM_PROB; i++)
            begin
                prob_reg[i] <= ihb_pkg::PROB_RESET;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ihb_pkg::CFG_FLIP_PROB_M4: prob_reg[0] <= cfg_data;
                ihb_pkg::CFG_FLIP_PROB_M2: prob_reg[1] <= cfg_data;
                ihb_pkg::CFG_FLIP_PROB_Z0: prob_reg[2] <= cfg_data;
                ihb_pkg::CFG_FLIP_PROB_P2: prob_reg[3] <= cfg_data;
                ihb_pkg::CFG_FLIP_PROB_P4: prob_reg[4] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign probs = prob_reg;

endmodule

FILE: rtl/ihb_site_calc.sv
// ----------------------------------------------------------------------------
// ihb_site_calc
// per-site decision: init draw, heat-bath flip or plain read
// ----------------------------------------------------------------------------
module ihb_site_calc (
    input  logic [1:0]                   op,
    input  logic [ihb_pkg::COLS-1:0]     row_bits,
    input  logic [ihb_pkg::COL_AW-1:0]   col,
    input  logic                         up_bit,
    input  logic                         dn_bit,
    input  logic [ihb_pkg::PROB_W-1:0]   rand_word,
    input  ihb_pkg::prob_tab_t           probs,
    output ihb_pkg::calc_res_t           res
);

    logic [ihb_pkg::COL_AW-1:0] col_l;
    logic [ihb_pkg::COL_AW-1:0] col_r;
    logic                       center;
    logic [3:0]                 agree;
    logic [ihb_pkg::CNT_W-1:0]  agree_cnt;
    logic [ihb_pkg::PROB_W-1:0] thresh;
    logic                       flip;

    assign col_l = (col == '0) ? ihb_pkg::COL_AW'(ihb_pkg::COLS - 1)
                               : col - ihb_pkg::COL_AW'(1);
    assign col_r = (col == ihb_pkg::COL_AW'(ihb_pkg::COLS - 1)) ? '0
                               : col + ihb_pkg::COL_AW'(1);
    assign center = row_bits[col];

    // spin times neighbour sum is 2*agree-4, so the table index is the agree count
    assign agree = ~({up_bit, dn_bit, row_bits[col_l], row_bits[col_r]} ^ {4{center}});
    assign agree_cnt = ihb_pkg::CNT_W'(agree[0]) + ihb_pkg::CNT_W'(agree[1])
                     + ihb_pkg::CNT_W'(agree[2]) + ihb_pkg::CNT_W'(agree[3]);

    always_comb
    begin
        case (agree_cnt)
            3'd0:    thresh = probs[0];
            3'd1:    thresh = probs[1];
            3'd2:    thresh = probs[2];
            3'd3:    thresh = probs[3];
            default: thresh = probs[4];
        endcase
    end

    assign flip = rand_word < thresh;

    always_comb
    begin
        case (op)
            ihb_pkg::OP_INIT:
            begin
                res.spin    = (rand_word >= ihb_pkg::HALF_WORD);
                res.flipped = 1'b0;
                res.wr      = 1'b1;
            end
            ihb_pkg::OP_UPDATE:
            begin
                res.spin    = center ^ flip;
                res.flipped = flip;
                res.wr      = flip;
            end
            default:
            begin
                // read, and the unused code behaves as read
                res.spin    = center;
                res.flipped = 1'b0;
                res.wr      = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/ising_heat_bath_site_update.sv
// ----------------------------------------------------------------------------
// ising_heat_bath_site_update: heat-bath spin update on a periodic lattice
// each item passes fetch, execute and the output register on its way to the result beat
// a new item is taken while the last one finishes execute; each site needs three row reads
//   (site, above, below) from the two read ports of the row ram; output stalls hold execute
// reset: thresholds go to one half, no result pending; spins undefined until written
// ----------------------------------------------------------------------------
`include "ising_heat_bath_site_update_defines.svh"

module ising_heat_bath_site_update (
    input  logic                            clk,
    input  logic                            rst_n,

    // item channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      op,
    input  logic [ihb_pkg::ROW_IN_W-1:0]    row,
    input  logic [ihb_pkg::COL_IN_W-1:0]    col,
    input  logic [ihb_pkg::PROB_W-1:0]      rand_word,

    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            spin,
    output logic                            flipped,

    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ihb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ihb_pkg::PROB_W-1:0]      cfg_data
);

    // ------------------------------------------------------------------------
    // the lattice is kept one row per ram word: a single read yields the site,
    // its left and right neighbours; the rows above and below take two more
    // reads. port a reads the site row and port b the row above at the input
    // beat, then port b reads the row below during the fetch cycle.
    // ------------------------------------------------------------------------

    ihb_pkg::state_t state_reg;
    ihb_pkg::state_t state_next;

    // item fields held for the site in flight
    logic [1:0]                    op_reg;
    logic [ihb_pkg::ROW_AW-1:0]    row_reg;
    logic [ihb_pkg::COL_AW-1:0]    col_reg;
    logic [ihb_pkg::PROB_W-1:0]    rand_reg;
    logic [ihb_pkg::ROW_AW-1:0]    dn_reg;
    logic [ihb_pkg::COLS-1:0]      rowr_reg;
    logic                          up_bit_reg;

    // forwarding of the row written at the same edge as the next item's reads
    logic [ihb_pkg::COLS-1:0]      wbuf_reg;
    logic                          fwd_a_reg;
    logic                          fwd_a_next;
    logic                          fwd_b_reg;
    logic                          fwd_b_next;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          spin_reg;
    logic                          flipped_reg;

    logic                          accept;
    logic                          out_free;
    logic                          done;
    logic                          fetching;

    logic [ihb_pkg::ROW_AW-1:0]    in_row_idx;
    logic [ihb_pkg::ROW_AW-1:0]    in_up_idx;
    logic [ihb_pkg::ROW_AW-1:0]    in_dn_idx;
    logic [ihb_pkg::COL_AW-1:0]    in_col_idx;

    logic                          ram_we;
    logic [ihb_pkg::ROW_AW-1:0]    raddr_a;
    logic [ihb_pkg::ROW_AW-1:0]    raddr_b;
    logic [ihb_pkg::COLS-1:0]      rdata_a;
    logic [ihb_pkg::COLS-1:0]      rdata_b;
    logic [ihb_pkg::COLS-1:0]      row_cur;
    logic [ihb_pkg::COLS-1:0]      row_up;
    logic [ihb_pkg::COLS-1:0]      row_new;

    ihb_pkg::prob_tab_t            probs;
    ihb_pkg::calc_res_t            calc;

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    // the result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // execute finishes only when its result can be parked
    assign done     = (state_reg == ihb_pkg::S_EXEC) && out_free;
    // a new item enters from idle, or overlaps the finishing execute cycle
    assign in_stall = !((state_reg == ihb_pkg::S_IDLE) || done);
    assign accept   = in_valid && !in_stall;
    assign fetching = (state_reg == ihb_pkg::S_FETCH);

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // site and neighbour row indexes, with wrap of out-of-range fields
    // ------------------------------------------------------------------------
    assign in_row_idx = ihb_pkg::ROW_AW'(ihb_pkg::wrap_index(row, ihb_pkg::ROWS));
    assign in_col_idx = ihb_pkg::COL_AW'(ihb_pkg::wrap_index(col, ihb_pkg::COLS));
    assign in_up_idx  = (in_row_idx == '0) ? ihb_pkg::ROW_AW'(ihb_pkg::ROWS - 1)
                                           : in_row_idx - ihb_pkg::ROW_AW'(1);
    assign in_dn_idx  = (in_row_idx == ihb_pkg::ROW_AW'(ihb_pkg::ROWS - 1)) ? '0
                                           : in_row_idx + ihb_pkg::ROW_AW'(1);

    // ------------------------------------------------------------------------
    // row ram
    // ------------------------------------------------------------------------
    // port b fetches the row below in fetch, and keeps re-reading it while
    // execute waits on the output, so the row is still there when it resumes
    always_comb
    begin
        raddr_a = in_row_idx;
        raddr_b = in_up_idx;
        if ((state_reg == ihb_pkg::S_FETCH) ||
            ((state_reg == ihb_pkg::S_EXEC) && !done))
        begin
            raddr_b = dn_reg;
        end
    end

    assign ram_we = done && calc.wr;

    ihb_ram #(
        .WIDTH (ihb_pkg::COLS),
        .DEPTH (ihb_pkg::ROWS)
    ) u_row_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (row_reg),
        .wdata   (row_new),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // reads issued at the edge of a write see the old row: take the written one
    assign row_cur = fwd_a_reg ? wbuf_reg : rdata_a;
    assign row_up  = fwd_b_reg ? wbuf_reg : rdata_b;

    assign fwd_a_next = ram_we && accept && (in_row_idx == row_reg);
    assign fwd_b_next = ram_we && accept && (in_up_idx == row_reg);

    // ------------------------------------------------------------------------
    // threshold registers and site decision
    // ------------------------------------------------------------------------
    ihb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .probs     (probs)
    );

    ihb_site_calc u_calc (
        .op        (op_reg),
        .row_bits  (rowr_reg),
        .col       (col_reg),
        .up_bit    (up_bit_reg),
        .dn_bit    (rdata_b[col_reg]),
        .rand_word (rand_reg),
        .probs     (probs),
        .res       (calc)
    );

    // site row with the new spin merged in
    always_comb
    begin
        row_new          = rowr_reg;
        row_new[col_reg] = calc.spin;
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ihb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ihb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ihb_pkg::S_FETCH;
                end
            end
            ihb_pkg::S_FETCH:
            begin
                state_next = ihb_pkg::S_EXEC;
            end
            ihb_pkg::S_EXEC:
            begin
                if (done)
                begin
                    state_next = accept ? ihb_pkg::S_FETCH : ihb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ihb_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    assign out_valid_next = done || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fwd_a_reg     <= 1'b0;
            fwd_b_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fwd_a_reg     <= fwd_a_next;
            fwd_b_reg     <= fwd_b_next;
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            row_reg  <= in_row_idx;
            col_reg  <= in_col_idx;
            rand_reg <= rand_word;
            dn_reg   <= in_dn_idx;
        end
        if (state_reg == ihb_pkg::S_FETCH)
        begin
            rowr_reg   <= row_cur;
            up_bit_reg <= row_up[col_reg];
        end
        if (ram_we)
        begin
            wbuf_reg <= row_new;
        end
        if (done)
        begin
            spin_reg    <= calc.spin;
            flipped_reg <= calc.flipped;
        end
    end

    assign out_valid = out_valid_reg;
    assign spin      = spin_reg;
    assign flipped   = flipped_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `IHB_ASSERT_IMP(a_fetch_blocks_input, fetching, in_stall, "item taken during fetch")
    `IHB_ASSERT_IMP(a_write_only_on_done, ram_we, done, "row write outside a finishing execute")
    `IHB_ASSERT_IMP(a_fwd_only_in_fetch, fwd_a_reg || fwd_b_reg, fetching, "forward outside fetch")
    `IHB_ASSERT_NXT(a_fetch_exec, fetching, state_reg == ihb_pkg::S_EXEC, "fetch without execute")
    `IHB_ASSERT_NXT(a_done_gives_result, done, out_valid, "finished item left no result")

endmodule

FILE: tb/sv/tb_ising_heat_bath_site_update.sv
// ----------------------------------------------------------------------------
// tb_ising_heat_bath_site_update: self-checking bench for the heat-bath site update
// a lattice tracker predicts spin and flip for every accepted item beat and
// checks each result beat in order; both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_ising_heat_bath_site_update;

    import ihb_pkg::*;

    // unnamed op code, handled by the block like a read
    localparam logic [1:0] OP_SPARE     = 2'd3;
    localparam int         RANDOM_ITEMS = 930;
    localparam int         NUM_PHASES   = 6;
    localparam int         IDLE_PAD     = 8;
    localparam int         CYCLE_LIMIT  = 1_000_000;

    // lattice edges used by the directed items
    localparam logic [ROW_IN_W-1:0] ROW_ONE  = ROW_IN_W'(1);
    localparam logic [ROW_IN_W-1:0] ROW_LAST = ROW_IN_W'(ROWS - 1);
    localparam logic [ROW_IN_W-1:0] ROW_PREV = ROW_IN_W'(ROWS - 2);
    localparam logic [COL_IN_W-1:0] COL_ONE  = COL_IN_W'(1);
    localparam logic [COL_IN_W-1:0] COL_LAST = COL_IN_W'(COLS - 1);
    localparam logic [COL_IN_W-1:0] COL_PREV = COL_IN_W'(COLS - 2);

    // one expected result beat
    typedef struct packed {
        logic spin;
        logic flipped;
    } spin_beat_t;

    // ------------------------------------------------------------------------
    // lattice tracker: own copy of the torus and the threshold table
    // ------------------------------------------------------------------------
    class lattice_tracker;
        bit                lattice [ROWS][COLS];
        logic [PROB_W-1:0] flip_thr [NUM_PROB];
        spin_beat_t        pending_spins [$];
        int                errors;

        function new();
            for (int k = 0; k < NUM_PROB; k++) begin
                flip_thr[k] = PROB_RESET;
            end
            errors = 0;
        endfunction

        function int spin_of(int r, int c);
            return lattice[r][c] ? 1 : -1;
        endfunction

        // indexes past the table are dropped by the block
        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [PROB_W-1:0] val);
            if (idx < NUM_PROB) begin
                flip_thr[idx] = val;
            end
        endfunction

        // called for every accepted item beat
        function void predict_site(logic [1:0] code, logic [ROW_IN_W-1:0] r_in,
                                   logic [COL_IN_W-1:0] c_in, logic [PROB_W-1:0] rnd);
            int         r;
            int         c;
            int         nsum;
            int         energy;
            int         sel;
            spin_beat_t res;
            r = int'(r_in) % ROWS;
            c = int'(c_in) % COLS;
            res.flipped = 1'b0;
            if (code == OP_INIT) begin
                // below one half gives spin -1
                lattice[r][c] = (rnd >= HALF_WORD);
            end else if (code == OP_UPDATE) begin
                // four neighbours on the torus
                nsum = spin_of((r + ROWS - 1) % ROWS, c) + spin_of((r + 1) % ROWS, c)
                     + spin_of(r, (c + COLS - 1) % COLS) + spin_of(r, (c + 1) % COLS);
                energy = spin_of(r, c) * nsum;
                sel = (energy + 4) / 2;
                // strict compare: a zero threshold never flips
                if (rnd < flip_thr[sel]) begin
                    lattice[r][c] = ~lattice[r][c];
                    res.flipped = 1'b1;
                end
            end
            res.spin = lattice[r][c];
            pending_spins.push_back(res);
        endfunction

        // called for every accepted result beat
        function void check_site_beat(logic got_spin, logic got_flipped);
            spin_beat_t want;
            if (pending_spins.size() == 0) begin
                $error("result beat with nothing outstanding: spin %0d flipped %0d",
                       got_spin, got_flipped);
                errors++;
                return;
            end
            want = pending_spins.pop_front();
            if (got_spin !== want.spin) begin
                $error("spin mismatch: expected %0d, actual %0d", want.spin, got_spin);
                errors++;
            end
            if (got_flipped !== want.flipped) begin
                $error("flipped mismatch: expected %0d, actual %0d",
                       want.flipped, got_flipped);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_spins.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           op;
    logic [ROW_IN_W-1:0]  row;
    logic [COL_IN_W-1:0]  col;
    logic [PROB_W-1:0]    rand_word;
    logic                 out_valid;
    logic                 out_stall;
    logic                 spin;
    logic                 flipped;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PROB_W-1:0]    cfg_data;

    lattice_tracker model;
    // sites that hold a defined spin; reads and neighbours stay inside this set
    bit             written [ROWS][COLS];
    // no idling on either side while set
    bit             quiet;
    int             stall_run;
    int             cycle_count;

    ising_heat_bath_site_update u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row       (row),
        .col       (col),
        .rand_word (rand_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .spin      (spin),
        .flipped   (flipped),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 unit clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // global watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int unsigned k;
        if (quiet) begin
            return 0;
        end
        k = $urandom_range(0, 99);
        if (k < 55) begin
            return 0;
        end else if (k < 85) begin
            return $urandom_range(1, 3);
        end else if (k < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                stall_run <= pick_gap();
            end
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            model.check_site_beat(spin, flipped);
        end
    end

    // random word: mostly uniform, with halves, extremes and threshold edges
    function automatic logic [PROB_W-1:0] pick_rand_word();
        int unsigned k;
        k = $urandom_range(0, 15);
        case (k)
            0: return '0;
            1: return '1;
            2: return HALF_WORD;
            3: return HALF_WORD - 1;
            4, 5: return model.flip_thr[$urandom_range(0, NUM_PROB - 1)]
                         + PROB_W'($urandom_range(0, 2)) - 1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // item channel driver: one beat, waits for acceptance
    // ------------------------------------------------------------------------
    task automatic send_site(input logic [1:0] code, input logic [ROW_IN_W-1:0] r,
                             input logic [COL_IN_W-1:0] c, input logic [PROB_W-1:0] rnd);
        int gap;
        gap = pick_gap();
        if (code == OP_INIT) begin
            written[r][c] = 1'b1;
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        row       <= r;
        col       <= c;
        rand_word <= rnd;
        do begin
            @(posedge clk);
        end while (in_stall);
        model.predict_site(code, r, c, rnd);
    endtask

    // wait until every result is back and the pipeline is empty
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (model.outstanding() > 0) begin
            @(posedge clk);
        end
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        model.set_threshold(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // full table load, plus writes to the unused indexes that must be dropped
    task automatic load_thresholds(input logic [PROB_W-1:0] m4, input logic [PROB_W-1:0] m2,
                                   input logic [PROB_W-1:0] z0, input logic [PROB_W-1:0] p2,
                                   input logic [PROB_W-1:0] p4);
        settle_idle();
        write_reg(CFG_FLIP_PROB_M4, m4);
        write_reg(CFG_FLIP_PROB_M2, m2);
        write_reg(CFG_FLIP_PROB_Z0, z0);
        write_reg(CFG_FLIP_PROB_P2, p2);
        write_reg(CFG_FLIP_PROB_P4, p4);
        for (int idx = NUM_PROB; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(CFG_IDX_W'(idx), $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // random item: mostly a small window that straddles both wrap edges, so
    // updates find written neighbours; some fully random sites as noise
    // ------------------------------------------------------------------------
    task automatic send_random_site();
        logic [1:0]          code;
        logic [ROW_IN_W-1:0] r;
        logic [COL_IN_W-1:0] c;
        int unsigned         k;
        int                  up;
        int                  dn;
        int                  lf;
        int                  rt;
        if ($urandom_range(0, 99) < 85) begin
            r = ROW_IN_W'(ROWS - 4 + $urandom_range(0, 7));
            c = COL_IN_W'(COLS - 4 + $urandom_range(0, 7));
        end else begin
            r = ROW_IN_W'($urandom);
            c = COL_IN_W'($urandom);
        end
        k = $urandom_range(0, 99);
        if (k < 15) begin
            code = OP_INIT;
        end else if (k < 75) begin
            code = OP_UPDATE;
        end else if (k < 90) begin
            code = OP_READ;
        end else begin
            code = OP_SPARE;
        end
        // never touch an undefined spin: write the missing site instead
        if (code != OP_INIT && !written[r][c]) begin
            code = OP_INIT;
        end
        if (code == OP_UPDATE) begin
            up = (int'(r) + ROWS - 1) % ROWS;
            dn = (int'(r) + 1) % ROWS;
            lf = (int'(c) + COLS - 1) % COLS;
            rt = (int'(c) + 1) % COLS;
            if (!written[up][c]) begin
                r    = ROW_IN_W'(up);
                code = OP_INIT;
            end else if (!written[dn][c]) begin
                r    = ROW_IN_W'(dn);
                code = OP_INIT;
            end else if (!written[r][lf]) begin
                c    = COL_IN_W'(lf);
                code = OP_INIT;
            end else if (!written[r][rt]) begin
                c    = COL_IN_W'(rt);
                code = OP_INIT;
            end
        end
        send_site(code, r, c, pick_rand_word());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        model       = new();
        quiet       = 1'b0;
        stall_run   = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_INIT;
        row         = '0;
        col         = '0;
        rand_word   = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_FLIP_PROB_M4;
        cfg_data    = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset thresholds (one half everywhere)
        send_site(OP_INIT, '0, '0, 32'h0000_0000);
        send_site(OP_INIT, '0, COL_ONE, HALF_WORD - 1);
        send_site(OP_INIT, '0, COL_LAST, HALF_WORD);
        send_site(OP_INIT, ROW_ONE, '0, 32'hFFFF_FFFF);
        send_site(OP_INIT, ROW_LAST, '0, 32'h0000_0001);
        send_site(OP_READ, '0, '0, 32'hFFFF_FFFF);
        // just under the threshold flips, exactly at it does not
        send_site(OP_UPDATE, '0, '0, HALF_WORD - 1);
        send_site(OP_UPDATE, '0, '0, HALF_WORD);
        send_site(OP_SPARE, '0, COL_LAST, 32'h1234_5678);
        // corner site, with the neighbours below and to the right across the wrap
        send_site(OP_INIT, ROW_LAST, COL_LAST, 32'hFFFF_FFFF);
        send_site(OP_INIT, ROW_PREV, COL_LAST, 32'h0000_0000);
        send_site(OP_INIT, ROW_LAST, COL_PREV, 32'hC000_0000);
        send_site(OP_UPDATE, ROW_LAST, COL_LAST, 32'h0000_0000);

        // zero threshold never flips, even with a zero word
        load_thresholds('0, '0, '0, '0, '0);
        send_site(OP_UPDATE, '0, '0, 32'h0000_0000);
        send_site(OP_UPDATE, ROW_LAST, COL_LAST, 32'h0000_0000);

        // full threshold: all-ones word still stays, one less flips
        load_thresholds('1, '1, '1, '1, '1);
        send_site(OP_UPDATE, '0, '0, 32'hFFFF_FFFF);
        send_site(OP_UPDATE, ROW_LAST, COL_LAST, 32'hFFFF_FFFE);

        // random phases, one threshold table each
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: load_thresholds(32'hFE00_0000, 32'hE000_0000, HALF_WORD,
                                   32'h2000_0000, 32'h0200_0000);
                1: load_thresholds('0, '0, '0, '0, '0);
                2: load_thresholds('1, '1, '1, '1, '1);
                3: load_thresholds($urandom, $urandom, $urandom, $urandom, $urandom);
                4: load_thresholds(32'h0200_0000, 32'h2000_0000, HALF_WORD,
                                   32'hE000_0000, 32'hFE00_0000);
                default: load_thresholds($urandom, '1, $urandom, '0, $urandom);
            endcase
            // one back-to-back phase with no idling on either side
            quiet = (phase == 3);
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
                send_random_site();
            end
        end
        quiet = 1'b0;

        settle_idle();
        if (model.errors == 0 && model.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
